// ===== rtl/i2c_master_byte_engine_top_assert.svh =====
// ---------------------------------------------------------------------------
// i2c master byte engine assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_TOP_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define I2CM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define I2CM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/i2cm_pkg.sv =====
// ---------------------------------------------------------------------------
// i2c master byte engine package
// command codes, phase codes and the result item type
// ---------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_ACK   = 3'd5,
        OP_NACK  = 3'd6
    } t_op;

    localparam logic [2:0] PH_A = 3'd0;
    localparam logic [2:0] PH_B = 3'd1;
    localparam logic [2:0] PH_C = 3'd2;
    localparam logic [2:0] PH_D = 3'd3;

    localparam logic [3:0] BYTE_BITS   = 4'd8;
    localparam logic [7:0] HALF_PERIOD_RST = 8'd30;

    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_error;
    } t_res;

    // wait counter load for a phase of n ticks, at least one
    function automatic logic [8:0] wait_len(input logic [8:0] n);
        logic [8:0] r;
        r = (n == 9'd0) ? 9'd0 : n - 9'd1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/i2cm_if.sv =====
// ---------------------------------------------------------------------------
// i2c master byte engine channels
// command, result and configuration handshake interfaces
// ---------------------------------------------------------------------------
`default_nettype none

interface i2cm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] write_byte;
    logic       sda_in;

    modport source (output valid, func, write_byte, sda_in, input ready);
    modport sink   (input valid, func, write_byte, sda_in, output ready);
endinterface

interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_error;

    modport source (output valid, scl_drive_low, sda_drive_low, busy_res, done_res,
                    read_byte, ack_error, input ready);
    modport sink   (input valid, scl_drive_low, sda_drive_low, busy_res, done_res,
                    read_byte, ack_error, output ready);
endinterface

interface i2cm_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] half_period;

    modport source (output valid, half_period, input ready);
    modport sink   (input valid, half_period, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2c_master_byte_engine_top.sv =====
// each accepted command tick's result item is registered in the output or skid stage
// throughput: one item per cycle while the skid stage is empty, set by the state update
// an output register plus one skid stage keep input taken while a result waits
// reset (synchronous, active low) clears the bus state, the output stages
// and sets the half period back to 30 ticks
// ---------------------------------------------------------------------------
// i2c master byte engine top level
// per-tick i2c master: start, stop, byte write/read, ack and nack
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine_top
    import i2cm_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    i2cm_cfg_if.sink   i_cfg,
    i2cm_cmd_if.sink   i_cmd,
    i2cm_res_if.source o_res
);

    logic [7:0] r_half_period;
    t_op        r_op,    n_op;
    logic [2:0] r_phase, n_phase;
    logic [3:0] r_bits,  n_bits;
    logic [7:0] r_shift, n_shift;
    logic [8:0] r_wait,  n_wait;
    logic       r_scl,   n_scl;
    logic       r_sda,   n_sda;
    logic       r_ack,   n_ack;
    logic       done;
    logic       accept;
    logic       pop;
    t_res       res;
    t_res       r_out;
    t_res       r_skid;
    logic       r_out_valid;
    logic       r_skid_valid;
    logic [8:0] h9;
    logic [7:0] rot;

    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = !r_skid_valid;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign pop         = r_out_valid && o_res.ready;
    assign h9          = {1'b0, r_half_period};
    assign rot         = {r_shift[6:0], r_shift[7]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
        end else if (i_cfg.valid) begin
            r_half_period <= i_cfg.half_period;
        end
    end

    // next state for one tick
    always_comb begin
        n_op    = r_op;
        n_phase = r_phase;
        n_bits  = r_bits;
        n_shift = r_shift;
        n_wait  = r_wait;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_ack   = r_ack;
        done    = 1'b0;
        if (accept) begin
            if (r_op == OP_IDLE) begin
                if (i_cmd.func >= 3'(OP_START) && i_cmd.func <= 3'(OP_NACK)) begin
                    n_op    = t_op'(i_cmd.func);
                    n_phase = PH_A;
                    n_wait  = wait_len(h9);
                    case (t_op'(i_cmd.func))
                        OP_START: begin
                            n_sda = 1'b1;
                        end
                        OP_STOP: begin
                            n_scl = 1'b1;
                            n_sda = 1'b1;
                        end
                        OP_WRITE: begin
                            n_shift = i_cmd.write_byte;
                            n_bits  = BYTE_BITS;
                            n_scl   = 1'b1;
                            n_sda   = ~i_cmd.write_byte[7];
                        end
                        OP_READ: begin
                            n_bits = BYTE_BITS;
                            n_scl  = 1'b1;
                            n_sda  = 1'b0;
                        end
                        OP_ACK: begin
                            n_scl = 1'b1;
                            n_sda = 1'b1;
                        end
                        default: begin
                            n_scl = 1'b1;
                            n_sda = 1'b0;
                        end
                    endcase
                end
            end else if (r_wait != 9'd0) begin
                n_wait = r_wait - 9'd1;
            end else begin
                case (r_op)
                    OP_STOP: begin
                        if (r_phase == PH_A) begin
                            n_phase = PH_B;
                            n_scl   = 1'b0;
                            n_wait  = wait_len({r_half_period, 1'b0});
                        end else if (r_phase == PH_B) begin
                            n_phase = PH_C;
                            n_sda   = 1'b0;
                            n_wait  = wait_len({2'b00, r_half_period[7:1]});
                        end else begin
                            done = 1'b1;
                        end
                    end
                    OP_WRITE: begin
                        if (r_phase == PH_A) begin
                            n_phase = PH_B;
                            n_scl   = 1'b0;
                            n_wait  = wait_len(h9);
                        end else if (r_phase == PH_B) begin
                            n_shift = rot;
                            n_wait  = wait_len(h9);
                            n_scl   = 1'b1;
                            if (r_bits > 4'd1) begin
                                n_bits  = r_bits - 4'd1;
                                n_phase = PH_A;
                                n_sda   = ~rot[7];
                            end else begin
                                n_bits  = 4'd0;
                                n_phase = PH_C;
                                n_sda   = 1'b0;
                            end
                        end else if (r_phase == PH_C) begin
                            n_phase = PH_D;
                            n_scl   = 1'b0;
                            n_sda   = 1'b0;
                            n_wait  = wait_len(h9);
                        end else begin
                            if (r_phase == PH_D) begin
                                n_ack = i_cmd.sda_in;
                            end
                            done = 1'b1;
                        end
                    end
                    OP_READ: begin
                        if (r_phase == PH_A) begin
                            n_phase = PH_B;
                            n_scl   = 1'b0;
                            n_wait  = wait_len(h9);
                        end else if (r_phase == PH_B) begin
                            n_shift = {r_shift[6:0], i_cmd.sda_in};
                            if (r_bits > 4'd1) begin
                                n_bits  = r_bits - 4'd1;
                                n_phase = PH_A;
                                n_scl   = 1'b1;
                                n_sda   = 1'b0;
                                n_wait  = wait_len(h9);
                            end else begin
                                n_bits = 4'd0;
                                done   = 1'b1;
                            end
                        end else begin
                            done = 1'b1;
                        end
                    end
                    OP_ACK, OP_NACK: begin
                        if (r_phase == PH_A) begin
                            n_phase = PH_B;
                            n_scl   = 1'b0;
                            n_wait  = wait_len(h9);
                        end else begin
                            if (r_phase == PH_B) begin
                                n_ack = i_cmd.sda_in;
                            end
                            done = 1'b1;
                        end
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
                if (done) begin
                    n_op    = OP_IDLE;
                    n_phase = PH_A;
                    n_wait  = 9'd0;
                end
            end
        end
    end

    always_comb begin
        res.scl_drive_low = n_scl;
        res.sda_drive_low = n_sda;
        res.busy_res      = (n_op != OP_IDLE);
        res.done_res      = done;
        res.read_byte     = n_shift;
        res.ack_error     = n_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= OP_IDLE;
            r_phase <= PH_A;
            r_bits  <= 4'd0;
            r_shift <= 8'd0;
            r_wait  <= 9'd0;
            r_scl   <= 1'b0;
            r_sda   <= 1'b0;
            r_ack   <= 1'b0;
        end else begin
            r_op    <= n_op;
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_shift <= n_shift;
            r_wait  <= n_wait;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_ack   <= n_ack;
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (!r_out_valid || pop) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.scl_drive_low = r_out.scl_drive_low;
    assign o_res.sda_drive_low = r_out.sda_drive_low;
    assign o_res.busy_res      = r_out.busy_res;
    assign o_res.done_res      = r_out.done_res;
    assign o_res.read_byte     = r_out.read_byte;
    assign o_res.ack_error     = r_out.ack_error;

endmodule

`default_nettype wire

// ===== rtl/i2cm_chk.sv =====
// ---------------------------------------------------------------------------
// i2c master byte engine checker
// port-level properties, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_byte_engine_top_assert.svh"

module i2cm_chk (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_cfg_valid,
    input wire       i_cfg_ready,
    input wire       i_cmd_ready,
    input wire       i_res_valid,
    input wire       i_res_ready,
    input wire       i_res_scl,
    input wire       i_res_sda,
    input wire       i_res_busy,
    input wire       i_res_done,
    input wire [7:0] i_res_byte,
    input wire       i_res_ack
);

    `I2CM_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_scl) && $stable(i_res_sda) && $stable(i_res_busy) && $stable(i_res_done) && $stable(i_res_byte) && $stable(i_res_ack), "result item changed while stalled")
    `I2CM_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, i_res_valid && i_res_done, !i_res_busy, "done item shows busy")
    `I2CM_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, !i_cmd_ready, i_res_valid, "input stalled with no result pending")
    `I2CM_ASSERT_IMP(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, i_cfg_ready, "config write refused")

endmodule

bind i2c_master_byte_engine_top i2cm_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cmd_ready (i_cmd.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_scl   (o_res.scl_drive_low),
    .i_res_sda   (o_res.sda_drive_low),
    .i_res_busy  (o_res.busy_res),
    .i_res_done  (o_res.done_res),
    .i_res_byte  (o_res.read_byte),
    .i_res_ack   (o_res.ack_error)
);

`default_nettype wire

// ===== tb/i2cm_engine_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// i2c master byte engine checker
// watches the tick, result and half period channels, runs its own model of
// the bus sequencer on every accepted tick and compares each result item
// field by field with the oldest predicted one
// ---------------------------------------------------------------------------

module i2cm_engine_checker
    import i2cm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    i2cm_cfg_if  i_cfg,
    i2cm_cmd_if  i_cmd,
    i2cm_res_if  i_res,
    output int   o_errors,
    output int   o_pending,
    output int   o_dones,
    output logic o_last_busy
);

    // model of the engine
    logic [7:0] half_per;
    t_op        op_now;
    logic [2:0] ph;
    logic [3:0] bits_rem;
    logic [7:0] shreg;
    logic [8:0] wait_cnt;
    logic       scl_low;
    logic       sda_low;
    logic       ack_err;

    t_res bus_expect[$];
    int   errors;
    int   done_total;
    logic last_busy;

    function automatic void phase_enter(logic [2:0] p, logic scl, logic sda, logic [8:0] ticks);
        ph       = p;
        scl_low  = scl;
        sda_low  = sda;
        wait_cnt = (ticks == 9'd0) ? 9'd0 : ticks - 9'd1;
    endfunction

    function automatic void bus_begin(t_op op, logic [7:0] wb);
        logic [8:0] h;
        h      = {1'b0, half_per};
        op_now = op;
        case (op)
            OP_START: phase_enter(PH_A, scl_low, 1'b1, h);
            OP_STOP:  phase_enter(PH_A, 1'b1, 1'b1, h);
            OP_WRITE: begin
                shreg    = wb;
                bits_rem = BYTE_BITS;
                phase_enter(PH_A, 1'b1, ~wb[7], h);
            end
            OP_READ: begin
                bits_rem = BYTE_BITS;
                phase_enter(PH_A, 1'b1, 1'b0, h);
            end
            OP_ACK:   phase_enter(PH_A, 1'b1, 1'b1, h);
            default:  phase_enter(PH_A, 1'b1, 1'b0, h);
        endcase
    endfunction

    // returns 1 when the running command has finished
    function automatic logic phase_advance(logic sda);
        logic [8:0] h;
        h = {1'b0, half_per};
        case (op_now)
            OP_STOP: begin
                if (ph == PH_A) begin
                    phase_enter(PH_B, 1'b0, sda_low, {half_per, 1'b0});
                    return 1'b0;
                end
                if (ph == PH_B) begin
                    phase_enter(PH_C, scl_low, 1'b0, h >> 1);
                    return 1'b0;
                end
                return 1'b1;
            end
            OP_WRITE: begin
                if (ph == PH_A) begin
                    phase_enter(PH_B, 1'b0, sda_low, h);
                    return 1'b0;
                end
                if (ph == PH_B) begin
                    shreg = {shreg[6:0], shreg[7]};
                    if (bits_rem > 4'd1) begin
                        bits_rem = bits_rem - 4'd1;
                        phase_enter(PH_A, 1'b1, ~shreg[7], h);
                    end else begin
                        bits_rem = 4'd0;
                        phase_enter(PH_C, 1'b1, 1'b0, h);
                    end
                    return 1'b0;
                end
                if (ph == PH_C) begin
                    phase_enter(PH_D, 1'b0, 1'b0, h);
                    return 1'b0;
                end
                if (ph == PH_D)
                    ack_err = sda;
                return 1'b1;
            end
            OP_READ: begin
                if (ph == PH_A) begin
                    phase_enter(PH_B, 1'b0, sda_low, h);
                    return 1'b0;
                end
                if (ph == PH_B) begin
                    shreg = {shreg[6:0], sda};
                    if (bits_rem > 4'd1) begin
                        bits_rem = bits_rem - 4'd1;
                        phase_enter(PH_A, 1'b1, 1'b0, h);
                        return 1'b0;
                    end
                    bits_rem = 4'd0;
                end
                return 1'b1;
            end
            OP_ACK, OP_NACK: begin
                if (ph == PH_A) begin
                    phase_enter(PH_B, 1'b0, sda_low, h);
                    return 1'b0;
                end
                if (ph == PH_B)
                    ack_err = sda;
                return 1'b1;
            end
            default: return 1'b1;
        endcase
    endfunction

    function automatic t_res engine_tick(logic [2:0] func, logic [7:0] wb, logic sda);
        t_res r;
        logic fin;
        fin = 1'b0;
        if (op_now == OP_IDLE) begin
            if (func >= OP_START && func <= OP_NACK)
                bus_begin(t_op'(func), wb);
        end else if (wait_cnt != 9'd0) begin
            wait_cnt = wait_cnt - 9'd1;
        end else begin
            fin = phase_advance(sda);
            if (fin) begin
                op_now   = OP_IDLE;
                ph       = PH_A;
                wait_cnt = 9'd0;
            end
        end
        r.scl_drive_low = scl_low;
        r.sda_drive_low = sda_low;
        r.busy_res      = (op_now != OP_IDLE);
        r.done_res      = fin;
        r.read_byte     = shreg;
        r.ack_error     = ack_err;
        return r;
    endfunction

    function automatic void field_check(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            half_per   = HALF_PERIOD_RST;
            op_now     = OP_IDLE;
            ph         = PH_A;
            bits_rem   = 4'd0;
            shreg      = 8'd0;
            wait_cnt   = 9'd0;
            scl_low    = 1'b0;
            sda_low    = 1'b0;
            ack_err    = 1'b0;
            errors     = 0;
            done_total = 0;
            last_busy  = 1'b0;
            bus_expect.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (bus_expect.size() == 0) begin
                    errors++;
                    $display("%0t: result item with no prediction waiting", $time);
                end else begin
                    want = bus_expect.pop_front();
                    field_check("scl_drive_low", 8'(want.scl_drive_low),
                                8'(i_res.scl_drive_low));
                    field_check("sda_drive_low", 8'(want.sda_drive_low),
                                8'(i_res.sda_drive_low));
                    field_check("busy_res", 8'(want.busy_res), 8'(i_res.busy_res));
                    field_check("done_res", 8'(want.done_res), 8'(i_res.done_res));
                    field_check("read_byte", want.read_byte, i_res.read_byte);
                    field_check("ack_error", 8'(want.ack_error), 8'(i_res.ack_error));
                end
                if (i_res.done_res === 1'b1)
                    done_total++;
                last_busy = i_res.busy_res;
            end
            if (i_cfg.valid && i_cfg.ready)
                half_per = i_cfg.half_period;
            if (i_cmd.valid && i_cmd.ready)
                bus_expect.push_back(engine_tick(i_cmd.func, i_cmd.write_byte, i_cmd.sda_in));
        end
        o_errors    <= errors;
        o_pending   <= bus_expect.size();
        o_dones     <= done_total;
        o_last_busy <= last_busy;
    end

endmodule

// ===== tb/i2c_master_byte_engine_top_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// i2c master byte engine testbench
// drives bus ticks carrying commands, bytes and sda levels through a directed
// set and then random start/write/read/ack/stop transactions over several half
// periods, with random stalls on both sides; the checker does the comparing
// ---------------------------------------------------------------------------

module i2c_master_byte_engine_top_test;
    import i2cm_pkg::*;

    typedef enum {SDA_LOW, SDA_HIGH, SDA_RAND} t_sda_mode;

    localparam logic [2:0] FUNC_UNUSED = 3'd7;

    logic clk;
    logic rst_n;
    bit   calm;
    bit   hold_req;
    int   cmd_total;

    int   err_count;
    int   pend;
    int   dones;
    logic last_busy;

    i2cm_cfg_if cfg_ch ();
    i2cm_cmd_if cmd_ch ();
    i2cm_res_if res_ch ();

    i2c_master_byte_engine_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    i2cm_engine_checker chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg       (cfg_ch),
        .i_cmd       (cmd_ch),
        .i_res       (res_ch),
        .o_errors    (err_count),
        .o_pending   (pend),
        .o_dones     (dones),
        .o_last_busy (last_busy)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side stalls
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (150) @(negedge clk);
                hold_req = 1'b0;
                res_ch.ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic sda_bit(t_sda_mode mode);
        case (mode)
            SDA_LOW:  return 1'b0;
            SDA_HIGH: return 1'b1;
            default:  return 1'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic t_sda_mode pick_mode();
        if ($urandom_range(0, 3) != 0)
            return SDA_RAND;
        return ($urandom_range(0, 1) != 0) ? SDA_HIGH : SDA_LOW;
    endfunction

    // called and returns at a falling edge
    task automatic send_tick(logic [2:0] f, logic [7:0] wb, logic sda);
        if (!calm && $urandom_range(0, 9) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.func       <= f;
        cmd_ch.write_byte <= wb;
        cmd_ch.sda_in     <= sda;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // one command, then ticks until its done pulse has come back
    task automatic run_cmd(t_op op, logic [7:0] wb, t_sda_mode mode);
        int         target;
        logic [2:0] stray;
        target = dones + 1;
        send_tick(op, wb, sda_bit(mode));
        // the engine is always still busy on the next tick
        stray = 3'($urandom_range(0, 7));
        send_tick(stray, 8'($urandom), sda_bit(mode));
        while (dones < target)
            send_tick(OP_IDLE, 8'($urandom), sda_bit(mode));
        cmd_total++;
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        while (pend != 0) @(negedge clk);
    endtask

    task automatic settle();
        int d;
        drain();
        d = dones;
        if (last_busy)
            while (dones == d)
                send_tick(OP_IDLE, 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    task automatic write_half_period(logic [7:0] v);
        drain();
        cfg_ch.valid       <= 1'b1;
        cfg_ch.half_period <= v;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_phase(logic [7:0] hp, int n_cmds, bit squeeze);
        int        first;
        int        k;
        int        kind;
        t_sda_mode mode;
        write_half_period(hp);
        first = cmd_total;
        while (cmd_total - first < n_cmds) begin
            kind = $urandom_range(0, 9);
            mode = pick_mode();
            if (kind < 7) begin
                run_cmd(OP_START, 8'($urandom), mode);
                if (squeeze) begin
                    hold_req = 1'b1;
                    squeeze  = 1'b0;
                end
                run_cmd(OP_WRITE, 8'($urandom), pick_mode());
                k = $urandom_range(1, 4);
                repeat (k) begin
                    if ($urandom_range(0, 1) != 0) begin
                        run_cmd(OP_WRITE, 8'($urandom), pick_mode());
                    end else begin
                        run_cmd(OP_READ, 8'($urandom), pick_mode());
                        run_cmd(($urandom_range(0, 1) != 0) ? OP_ACK : OP_NACK,
                                8'($urandom), pick_mode());
                    end
                end
                if ($urandom_range(0, 4) != 0)
                    run_cmd(OP_STOP, 8'($urandom), mode);
            end else if (kind < 9) begin
                repeat ($urandom_range(1, 3))
                    run_cmd(t_op'($urandom_range(1, 6)), 8'($urandom), pick_mode());
            end else begin
                repeat ($urandom_range(3, 20))
                    send_tick(3'($urandom_range(0, 7)), 8'($urandom),
                              1'($urandom_range(0, 1)));
                settle();
            end
        end
    endtask

    initial begin
        int waited;
        rst_n              = 1'b0;
        calm               = 1'b0;
        hold_req           = 1'b0;
        cmd_total          = 0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.func        = OP_IDLE;
        cmd_ch.write_byte  = 8'd0;
        cmd_ch.sda_in      = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.half_period = 8'd0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default half period out of reset
        run_cmd(OP_START, 8'h00, SDA_RAND);

        write_half_period(8'd1);
        send_tick(FUNC_UNUSED, 8'hFF, 1'b1);
        send_tick(OP_IDLE, 8'h00, 1'b0);
        run_cmd(OP_START, 8'h00, SDA_RAND);
        hold_req = 1'b1;
        run_cmd(OP_WRITE, 8'h00, SDA_LOW);
        run_cmd(OP_WRITE, 8'hFF, SDA_HIGH);
        run_cmd(OP_WRITE, 8'h5A, SDA_RAND);
        run_cmd(OP_READ, 8'h00, SDA_HIGH);
        run_cmd(OP_ACK, 8'h00, SDA_LOW);
        run_cmd(OP_READ, 8'hFF, SDA_LOW);
        run_cmd(OP_NACK, 8'h00, SDA_HIGH);
        run_cmd(OP_READ, 8'h00, SDA_RAND);
        run_cmd(OP_ACK, 8'h00, SDA_HIGH);
        run_cmd(OP_START, 8'h00, SDA_RAND);
        run_cmd(OP_STOP, 8'h00, SDA_RAND);
        run_cmd(OP_STOP, 8'h00, SDA_RAND);

        // zero half period stretched to one tick
        write_half_period(8'd0);
        run_cmd(OP_START, 8'h00, SDA_RAND);
        run_cmd(OP_WRITE, 8'h3C, SDA_RAND);
        run_cmd(OP_STOP, 8'h00, SDA_RAND);

        // odd half period, short last stop phase
        write_half_period(8'd3);
        run_cmd(OP_STOP, 8'h00, SDA_RAND);

        random_phase(8'd2, 5, 1'b1);
        random_phase(8'd1, 5, 1'b0);
        calm = 1'b1;
        random_phase(8'd1, 5, 1'b0);

        cmd_ch.valid <= 1'b0;
        waited = 0;
        @(negedge clk);
        while (pend != 0 && waited < 100000) begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);
        if (err_count == 0 && pend == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/i2cm_pkg.sv
rtl/i2cm_if.sv
rtl/i2c_master_byte_engine_top.sv
rtl/i2cm_chk.sv
tb/i2cm_engine_checker.sv
tb/i2c_master_byte_engine_top_test.sv
